>>> design/spool_pkg.sv
`default_nettype none

package spool_pkg;

  // Fixed field widths of the request and result items
  localparam int OP_W     = 2;
  localparam int PART_W   = 32;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int REFS_W   = 8;
  localparam int CFG_W    = 7;

  // Packed result item: status, slot_index, data_ready, references
  localparam int RES_W = STATUS_W + SLOT_W + 1 + REFS_W;

  // Reset value of the slots_in_use register
  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_GET       = 2'd0,
    OP_RELEASE   = 2'd1,
    OP_SET_READY = 2'd2,
    OP_POLL      = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 2'd0,
    ST_CLAIMED = 2'd1,
    ST_BUSY    = 2'd2,
    ST_DONE    = 2'd3
  } status_t;

endpackage

`default_nettype wire

>>> design/spool_ram.sv
`default_nettype none

module spool_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/spool_fifo.sv
`default_nettype none

module spool_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> design/spool_front.sv
`default_nettype none

module spool_front #(
  parameter int SLOTS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [spool_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                         clearing,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [spool_pkg::OP_W-1:0]   operation,
  input  wire logic [spool_pkg::PART_W-1:0] partition,
  input  wire logic [spool_pkg::SLOT_W-1:0] slot,
  output logic                              req_push,
  output logic [spool_pkg::OP_W + spool_pkg::PART_W + (SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]
                                            req_data,
  input  wire logic                         req_full
);

  localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW     = ($clog2(SLOTS + 1) > spool_pkg::CFG_W) ?
                          $clog2(SLOTS + 1) : spool_pkg::CFG_W;
  localparam int STEPS  = spool_pkg::PART_W;
  localparam int CNT_W  = $clog2(STEPS);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_HOLD
  } fstate_t;

  fstate_t                       state;
  logic [spool_pkg::CFG_W-1:0]   slots_in_use;
  spool_pkg::op_t                op_q;
  logic [spool_pkg::PART_W-1:0]  part_q;
  logic [spool_pkg::PART_W-1:0]  dvd;
  logic [DW-1:0]                 dvs;
  logic [DW-1:0]                 rem;
  logic [CNT_W-1:0]              step;
  logic [DW:0]                   trial;
  logic [DW:0]                   trial_sub;
  logic [DW-1:0]                 rem_next;
  logic [DW-1:0]                 get_dvs;
  logic                          accept;

  assign full     = (state != F_IDLE) || clearing;
  assign accept   = push && !full;
  assign req_push = (state == F_HOLD) && !req_full;
  assign req_data = {op_q, part_q, rem[IW-1:0]};

  // Clamp the mapping divisor into 1..SLOTS
  always_comb begin
    get_dvs = DW'(slots_in_use);
    if (slots_in_use == '0) begin
      get_dvs = DW'(1);
    end else if (DW'(slots_in_use) > DW'(SLOTS)) begin
      get_dvs = DW'(SLOTS);
    end
  end

  // One restoring remainder step
  always_comb begin
    trial     = {rem, dvd[spool_pkg::PART_W-1]};
    trial_sub = trial - {1'b0, dvs};
    rem_next  = (trial >= {1'b0, dvs}) ? trial_sub[DW-1:0] : trial[DW-1:0];
  end

  // Hold the mapping register
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= spool_pkg::SLOTS_IN_USE_RESET;
    end else if (cfg_write) begin
      slots_in_use <= cfg_data;
    end
  end

  // Accept, reduce to a slot index, hand over to the request queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            op_q   <= spool_pkg::op_t'(operation);
            part_q <= partition;
            if (spool_pkg::op_t'(operation) == spool_pkg::OP_GET) begin
              dvd <= partition;
              dvs <= get_dvs;
            end else begin
              dvd <= spool_pkg::PART_W'(slot);
              dvs <= DW'(SLOTS);
            end
            rem   <= '0;
            step  <= '0;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          rem  <= rem_next;
          dvd  <= {dvd[spool_pkg::PART_W-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == CNT_W'(STEPS - 1)) begin
            state <= F_HOLD;
          end
        end
        F_HOLD: begin
          if (!req_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/spool_back.sv
`default_nettype none

module spool_back #(
  parameter int SLOTS     = 64,
  parameter int REF_WIDTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  output logic                             clearing,
  input  wire logic                        req_empty,
  input  wire logic [spool_pkg::OP_W + spool_pkg::PART_W + (SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]
                                           req_data,
  output logic                             req_pop,
  input  wire logic                        res_full,
  output logic                             res_push,
  output logic [spool_pkg::RES_W-1:0]      res_data
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW  = spool_pkg::PART_W;
  localparam int E_W = PW + 2 + REF_WIDTH;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_MODIFY
  } bstate_t;

  bstate_t                state;
  logic [IW-1:0]          clr;
  spool_pkg::op_t         op_q;
  logic [PW-1:0]          part_q;
  logic [IW-1:0]          idx_q;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [E_W-1:0]         ram_wdata;
  logic                   ram_re;
  logic [E_W-1:0]         ram_rdata;

  logic [PW-1:0]          tag;
  logic                   valid;
  logic                   ready;
  logic [REF_WIDTH-1:0]   cnt;
  logic [PW-1:0]          tag_new;
  logic                   valid_new;
  logic                   ready_new;
  logic [REF_WIDTH-1:0]   cnt_new;
  spool_pkg::status_t     status;

  assign clearing = (state == B_CLEAR);
  assign ram_re   = (state == B_IDLE) && !req_empty && !res_full;
  assign req_pop  = ram_re;
  assign res_push = (state == B_MODIFY);
  assign {tag, valid, ready, cnt} = ram_rdata;
  assign res_data = {status, spool_pkg::SLOT_W'(idx_q), ready_new,
                     spool_pkg::REFS_W'(cnt_new)};

  // Update one slot entry
  always_comb begin
    tag_new   = tag;
    valid_new = valid;
    ready_new = ready;
    cnt_new   = cnt;
    status    = spool_pkg::ST_DONE;
    case (op_q)
      spool_pkg::OP_GET: begin
        if (valid && (tag == part_q)) begin
          if (cnt != {REF_WIDTH{1'b1}}) begin
            cnt_new = cnt + 1'b1;
          end
          status = spool_pkg::ST_HIT;
        end else if (cnt != '0) begin
          status = spool_pkg::ST_BUSY;
        end else begin
          tag_new   = part_q;
          valid_new = 1'b1;
          ready_new = 1'b0;
          cnt_new   = REF_WIDTH'(1);
          status    = spool_pkg::ST_CLAIMED;
        end
      end
      spool_pkg::OP_RELEASE: begin
        if (cnt != '0) begin
          cnt_new = cnt - 1'b1;
        end
      end
      spool_pkg::OP_SET_READY: begin
        ready_new = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Select the write: clearing sweep or read-modify-write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {tag_new, valid_new, ready_new, cnt_new};
    case (state)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = '0;
      end
      B_MODIFY: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sweep after reset, then take one request at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr   <= '0;
    end else begin
      case (state)
        B_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == IW'(SLOTS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (ram_re) begin
            op_q   <= spool_pkg::op_t'(req_data[IW + PW +: spool_pkg::OP_W]);
            part_q <= req_data[IW +: PW];
            idx_q  <= req_data[IW-1:0];
            state  <= B_MODIFY;
          end
        end
        B_MODIFY: begin
          state <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  spool_ram #(
    .WIDTH (E_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (req_data[IW-1:0]),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

>>> design/refcounted_direct_mapped_slot_pool.sv
`default_nettype none

// Reference-counted direct-mapped slot pool. A get maps its partition to slot
// (partition mod slots_in_use, zero read as one, above SLOTS clamped to SLOTS)
// and hits, claims or is refused as busy; release, set ready and poll address
// a slot directly. Every request gives exactly one result, in order. Each
// request passes the front end (accept, a 32-step one-bit-per-cycle remainder
// loop, hand-off), taking no new request before the hand-off; the slot table
// update behind it (table read, then write back) overlaps the next item's
// remainder loop. After reset the table is swept to zero, one slot per cycle,
// while full stays high; writes to slots_in_use are taken at any time, but
// should be made only while the pool is idle.
module refcounted_direct_mapped_slot_pool #(
  parameter int SLOTS     = 64,
  parameter int REF_WIDTH = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [spool_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [spool_pkg::OP_W-1:0]     operation,
  input  wire logic [spool_pkg::PART_W-1:0]   partition,
  input  wire logic [spool_pkg::SLOT_W-1:0]   slot,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [spool_pkg::STATUS_W-1:0]      status,
  output logic [spool_pkg::SLOT_W-1:0]        slot_index,
  output logic                                data_ready,
  output logic [spool_pkg::REFS_W-1:0]        references
);

  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int REQ_W = spool_pkg::OP_W + spool_pkg::PART_W + IW;

  logic                        clearing;
  logic                        req_push;
  logic [REQ_W-1:0]            req_wdata;
  logic                        req_full;
  logic                        req_pop;
  logic [REQ_W-1:0]            req_rdata;
  logic                        req_empty;
  logic                        res_push;
  logic [spool_pkg::RES_W-1:0] res_wdata;
  logic                        res_full;
  logic [spool_pkg::RES_W-1:0] res_rdata;

  assign {status, slot_index, data_ready, references} = res_rdata;

  spool_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .push      (push),
    .full      (full),
    .operation (operation),
    .partition (partition),
    .slot      (slot),
    .req_push  (req_push),
    .req_data  (req_wdata),
    .req_full  (req_full)
  );

  spool_fifo #(
    .WIDTH (REQ_W),
    .DEPTH (2)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (req_push),
    .wdata (req_wdata),
    .full  (req_full),
    .pop   (req_pop),
    .rdata (req_rdata),
    .empty (req_empty)
  );

  spool_back #(
    .SLOTS     (SLOTS),
    .REF_WIDTH (REF_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .req_empty (req_empty),
    .req_data  (req_rdata),
    .req_pop   (req_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  spool_fifo #(
    .WIDTH (spool_pkg::RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

endmodule

`default_nettype wire

>>> design/spool_checker.sv
`default_nettype none

module spool_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            push,
  input wire logic                            full,
  input wire logic                            empty,
  input wire logic                            pop,
  input wire logic [spool_pkg::STATUS_W-1:0]  status,
  input wire logic [spool_pkg::SLOT_W-1:0]    slot_index,
  input wire logic                            data_ready,
  input wire logic [spool_pkg::REFS_W-1:0]    references
);

  // Reset starts the table sweep with no result waiting
  a_reset_state: assert property (@(posedge clk) rst |=> (full && empty))
    else $error("pool not full and empty after reset");

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(slot_index)
                          && $stable(data_ready) && $stable(references)))
    else $error("waiting result changed");

  // A fresh claim carries one reference and no ready data
  a_claim_fresh: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == spool_pkg::ST_CLAIMED)) |-> (references == 8'd1 && !data_ready))
    else $error("claimed slot not fresh");

  // A hit always leaves a reference held
  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == spool_pkg::ST_HIT)) |-> (references != '0))
    else $error("hit with zero references");

  // An accepted request occupies the front end
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front end took a second request at once");

endmodule

bind refcounted_direct_mapped_slot_pool spool_checker u_spool_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .status     (status),
  .slot_index (slot_index),
  .data_ready (data_ready),
  .references (references)
);

`default_nettype wire

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SLOTS = 64;
  localparam int POOL_REF_W = 8;

  typedef struct packed {
    spool_pkg::op_t               op;
    logic [spool_pkg::PART_W-1:0] part;
    logic [spool_pkg::SLOT_W-1:0] slot;
  } slot_request_t;

  typedef struct packed {
    spool_pkg::status_t           st;
    logic [spool_pkg::SLOT_W-1:0] idx;
    logic                         rdy;
    logic [spool_pkg::REFS_W-1:0] refs;
  } slot_result_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [spool_pkg::CFG_W-1:0]    cfg_data = '0;
  logic                           push = 1'b0;
  logic                           full;
  logic [spool_pkg::OP_W-1:0]     operation = '0;
  logic [spool_pkg::PART_W-1:0]   partition = '0;
  logic [spool_pkg::SLOT_W-1:0]   slot = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [spool_pkg::STATUS_W-1:0] status;
  logic [spool_pkg::SLOT_W-1:0]   slot_index;
  logic                           data_ready;
  logic [spool_pkg::REFS_W-1:0]   references;

  refcounted_direct_mapped_slot_pool #(
    .SLOTS     (POOL_SLOTS),
    .REF_WIDTH (POOL_REF_W)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .partition  (partition),
    .slot       (slot),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .slot_index (slot_index),
    .data_ready (data_ready),
    .references (references)
  );

  // Shadow copy of the slot table and the divisor register
  logic [spool_pkg::PART_W-1:0] shadow_tag   [POOL_SLOTS];
  logic                         shadow_valid [POOL_SLOTS];
  logic [POOL_REF_W-1:0]        shadow_refs  [POOL_SLOTS];
  logic                         shadow_ready [POOL_SLOTS];
  logic [spool_pkg::CFG_W-1:0]  shadow_slots_in_use = spool_pkg::SLOTS_IN_USE_RESET;

  slot_request_t pending_requests [$];
  slot_result_t  expected_results [$];

  int unsigned n_accepted, n_checked, n_failures, n_cfg_writes;
  int unsigned n_hits, n_claims, n_busy, n_saturated, n_other_ops;

  // Transmit and receive pacing
  slot_request_t tx_cur;
  logic          tx_live = 1'b0;
  int unsigned   tx_gap = 0;
  logic          tx_calm = 1'b0;
  int unsigned   rx_wait = 0;
  logic          rx_calm = 1'b0;
  logic          rx_hold = 1'b0;
  logic          hold_go = 1'b0;

  initial begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_refs[i]  = '0;
      shadow_ready[i] = 1'b0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Effective modulo divisor: zero acts as one, oversize clamps to the pool
  function automatic int unsigned eff_divisor(logic [spool_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > POOL_SLOTS) return POOL_SLOTS;
    return 32'(v);
  endfunction

  // Apply one request to the shadow table and return the slot's answer
  function automatic slot_result_t pool_apply(slot_request_t rq);
    slot_result_t                 r;
    logic [spool_pkg::PART_W-1:0] rem;
    logic [spool_pkg::SLOT_W-1:0] i;
    r.st = spool_pkg::ST_DONE;
    if (rq.op == spool_pkg::OP_GET) begin
      rem = rq.part % eff_divisor(shadow_slots_in_use);
      i = rem[spool_pkg::SLOT_W-1:0];
      if (shadow_valid[i] && shadow_tag[i] == rq.part) begin
        if (shadow_refs[i] != '1) shadow_refs[i] = shadow_refs[i] + 1'b1;
        else n_saturated++;
        r.st = spool_pkg::ST_HIT;
        n_hits++;
      end else if (shadow_refs[i] != 0) begin
        r.st = spool_pkg::ST_BUSY;
        n_busy++;
      end else begin
        shadow_tag[i]   = rq.part;
        shadow_valid[i] = 1'b1;
        shadow_refs[i]  = POOL_REF_W'(1);
        shadow_ready[i] = 1'b0;
        r.st = spool_pkg::ST_CLAIMED;
        n_claims++;
      end
    end else begin
      i = rq.slot;
      if (rq.op == spool_pkg::OP_RELEASE && shadow_refs[i] != 0) begin
        shadow_refs[i] = shadow_refs[i] - 1'b1;
      end
      if (rq.op == spool_pkg::OP_SET_READY) shadow_ready[i] = 1'b1;
      n_other_ops++;
    end
    r.idx  = i;
    r.rdy  = shadow_ready[i];
    r.refs = shadow_refs[i];
    return r;
  endfunction

  // Driver: offer queued requests, predict each one the block takes
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      tx_live = 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(pool_apply(tx_cur));
        n_accepted++;
        tx_live = 1'b0;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
      end
      if (!tx_live) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_requests.size() > 0) begin
          tx_cur = pending_requests.pop_front();
          tx_live = 1'b1;
        end
      end
      push      <= tx_live;
      operation <= tx_cur.op;
      partition <= tx_cur.part;
      slot      <= tx_cur.slot;
    end
  end

  // Monitor: take results with random stalls, compare with the oldest prediction
  always @(posedge clk) begin
    slot_result_t got, want;
    if (rst) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        got = '{spool_pkg::status_t'(status), slot_index, data_ready, references};
        if (expected_results.size() == 0) begin
          n_failures++;
          if (n_failures <= 10)
            $display("unexpected result: status %0d slot %0d ready %0d refs %0d",
                     got.st, got.idx, got.rdy, got.refs);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            n_failures++;
            if (n_failures <= 10)
              $display({"mismatch on result %0d: expected st %0d slot %0d rdy %0d ",
                        "refs %0d, got st %0d slot %0d rdy %0d refs %0d"},
                       n_checked, want.st, want.idx, want.rdy, want.refs,
                       got.st, got.idx, got.rdy, got.refs);
          end
          n_checked++;
        end
        rx_wait = rx_calm ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      pop <= (rx_wait == 0) && !rx_hold;
    end
  end

  // Long receiver hold so the pool backs up and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (3000) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic add_req(spool_pkg::op_t op, logic [spool_pkg::PART_W-1:0] p,
                         logic [spool_pkg::SLOT_W-1:0] s);
    pending_requests.push_back('{op, p, s});
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || tx_live || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Drain, let the table update settle, then change the divisor
  task automatic write_slots_in_use(logic [spool_pkg::CFG_W-1:0] v);
    wait_idle();
    repeat (40) @(posedge clk);
    cfg_data  <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_slots_in_use = v;
    n_cfg_writes++;
  endtask

  // Mostly traffic on a few partitions, some colliding on one slot, plus noise
  task automatic queue_mixed(int count, logic [spool_pkg::CFG_W-1:0] cfg);
    logic [spool_pkg::PART_W-1:0] hot [6];
    logic [spool_pkg::PART_W-1:0] base, p;
    int unsigned                  div;
    int                           pick;
    div  = eff_divisor(cfg);
    base = $urandom_range(0, 32'hFFF0_0000);
    for (int k = 0; k < 6; k++)
      hot[k] = (k < 4) ? base + k * div : $urandom();
    for (int k = 0; k < count; k++) begin
      p = hot[$urandom_range(0, 5)];
      pick = $urandom_range(0, 99);
      if (pick < 35)
        add_req(spool_pkg::OP_GET, p, spool_pkg::SLOT_W'($urandom()));
      else if (pick < 57)
        add_req(spool_pkg::OP_RELEASE, $urandom(), spool_pkg::SLOT_W'(p % div));
      else if (pick < 67)
        add_req(spool_pkg::OP_SET_READY, $urandom(), spool_pkg::SLOT_W'(p % div));
      else if (pick < 77)
        add_req(spool_pkg::OP_POLL, $urandom(), spool_pkg::SLOT_W'(p % div));
      else if (pick < 85)
        add_req(spool_pkg::op_t'($urandom_range(1, 3)), $urandom(),
                spool_pkg::SLOT_W'($urandom()));
      else
        add_req(spool_pkg::op_t'($urandom_range(0, 3)), $urandom(),
                spool_pkg::SLOT_W'($urandom()));
    end
  endtask

  initial begin
    logic [spool_pkg::PART_W-1:0] p;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: claim, hit, busy, release to zero and below, zero-count hit
    add_req(spool_pkg::OP_GET, 32'd0, 6'd0);
    add_req(spool_pkg::OP_GET, 32'd0, 6'd0);
    add_req(spool_pkg::OP_SET_READY, 32'd0, 6'd0);
    add_req(spool_pkg::OP_POLL, 32'd0, 6'd0);
    add_req(spool_pkg::OP_GET, 32'd64, 6'd0);
    add_req(spool_pkg::OP_RELEASE, 32'd0, 6'd0);
    add_req(spool_pkg::OP_RELEASE, 32'd0, 6'd0);
    add_req(spool_pkg::OP_RELEASE, 32'd0, 6'd0);
    add_req(spool_pkg::OP_GET, 32'd0, 6'd0);
    add_req(spool_pkg::OP_RELEASE, 32'd0, 6'd0);
    add_req(spool_pkg::OP_GET, 32'd64, 6'd0);
    add_req(spool_pkg::OP_GET, 32'hFFFF_FFFF, 6'd0);
    add_req(spool_pkg::OP_POLL, 32'hFFFF_FFFF, 6'd63);
    add_req(spool_pkg::OP_SET_READY, 32'd0, 6'd63);
    add_req(spool_pkg::OP_RELEASE, 32'd0, 6'd63);
    add_req(spool_pkg::OP_RELEASE, 32'd0, 6'd63);
    add_req(spool_pkg::OP_POLL, 32'd0, 6'd63);
    add_req(spool_pkg::OP_GET, 32'hFFFF_FFFF, 6'd17);
    add_req(spool_pkg::OP_GET, 32'h8000_0000, 6'd63);
    add_req(spool_pkg::OP_RELEASE, 32'hFFFF_FFFF, 6'd0);
    add_req(spool_pkg::OP_GET, 32'd5, 6'd63);
    add_req(spool_pkg::OP_POLL, 32'd5, 6'd5);
    queue_mixed(60, spool_pkg::SLOTS_IN_USE_RESET);

    // Single slot: hammer one partition past count saturation
    write_slots_in_use(7'd1);
    p = $urandom();
    for (int k = 0; k < 262; k++)
      add_req(spool_pkg::OP_GET, p, spool_pkg::SLOT_W'($urandom()));
    add_req(spool_pkg::OP_SET_READY, $urandom(), 6'd0);
    add_req(spool_pkg::OP_POLL, $urandom(), 6'd0);
    add_req(spool_pkg::OP_RELEASE, $urandom(), 6'd0);
    queue_mixed(20, 7'd1);

    // Zero and oversize divisors
    write_slots_in_use(7'd0);
    queue_mixed(50, 7'd0);
    write_slots_in_use(7'd127);
    queue_mixed(50, 7'd127);

    // Small divisor: slots above it still reachable directly
    write_slots_in_use(7'd7);
    queue_mixed(50, 7'd7);

    // Back-pressure phase
    write_slots_in_use(7'd33);
    hold_go = 1'b1;
    queue_mixed(100, 7'd33);

    p = $urandom_range(2, 63);
    write_slots_in_use(p[spool_pkg::CFG_W-1:0]);
    queue_mixed(50, p[spool_pkg::CFG_W-1:0]);

    wait_idle();
    repeat (100) @(posedge clk);
    $display("covered %0d requests over %0d divisor changes: %0d hits (%0d saturated),",
             n_accepted, n_cfg_writes, n_hits, n_saturated);
    $display("%0d claims, %0d busy, %0d release/ready/poll; %0d checked, %0d failures",
             n_claims, n_busy, n_other_ops, n_checked, n_failures);
    if (n_failures == 0 && expected_results.size() == 0) begin
      $display("[refcounted_direct_mapped_slot_pool] OK");
    end else begin
      $display("[refcounted_direct_mapped_slot_pool] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("[refcounted_direct_mapped_slot_pool] ERROR");
    $finish;
  end

endmodule
